// ----- rtl/cft_pkg.sv -----
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types, register codes and constants of the cycloid foot trajectory.
// ----------------------------------------------------------------------------
package cft_pkg;

	// register index codes, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_SWING_TICKS    = 3'd0,
		REG_STANCE_TICKS   = 3'd1,
		REG_START_POSITION = 3'd2,
		REG_END_POSITION   = 3'd3,
		REG_LIFT_HEIGHT    = 3'd4,
		REG_LIFT_OFFSET    = 3'd5
	} cfg_reg_t;

	// reset values
	localparam logic [7:0]        RST_SWING_TICKS    = 8'd10;
	localparam logic [7:0]        RST_STANCE_TICKS   = 8'd15;
	localparam logic signed [7:0] RST_START_POSITION = 8'sd30;
	localparam logic signed [7:0] RST_END_POSITION   = -8'sd30;
	localparam logic [6:0]        RST_LIFT_HEIGHT    = 7'd20;
	localparam logic signed [6:0] RST_LIFT_OFFSET    = 7'sd0;

	// fixed point constants
	localparam longint unsigned TWO_PI_Q28    = 64'd1686629713;
	localparam logic [22:0]     INV_TWO_PI_Q24 = 23'd2670177;
	localparam int              FRAC_BITS     = 30;

	// Taylor denominators (2i)(2i+1)
	localparam longint unsigned TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// quarter-wave sine entry k of a table of 2^lg phases, Q1.15
	function automatic logic [15:0] quarter_sine(input int unsigned k, input int unsigned lg);
		longint unsigned x;
		longint unsigned sum;
		longint unsigned term;
		longint unsigned r;
		x    = (longint'(k) * TWO_PI_Q28) >> lg;
		sum  = x;
		term = x;
		for (int i = 1; i <= 8; i++) begin
			term = (term * x) >> 28;
			term = (term * x) >> 28;
			term = term / TAYLOR_DIV[i-1];
			if (i % 2 == 1) begin
				sum = (term <= sum) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		r = (sum + 64'd4096) >> 13;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[15:0];
	endfunction

	// clamp to the 9 bit result range
	function automatic logic signed [8:0] sat9(input logic signed [47:0] v);
		if (v < -48'sd256) begin
			return -9'sd256;
		end else if (v > 48'sd255) begin
			return 9'sd255;
		end
		return v[8:0];
	endfunction

endpackage

// ----- rtl/cft_in_if.sv -----
// ----------------------------------------------------------------------------
// cft_in_if
// Input channel: one gait tick index per item.
// ----------------------------------------------------------------------------
interface cft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

// ----- rtl/cft_out_if.sv -----
// ----------------------------------------------------------------------------
// cft_out_if
// Output channel: foot coordinates, one item per input item.
// ----------------------------------------------------------------------------
interface cft_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] horizontal_position;
	logic signed [8:0] vertical_position;

	modport source (output valid, output horizontal_position, output vertical_position,
		input ready);
	modport sink (input valid, input horizontal_position, input vertical_position,
		output ready);
endinterface

// ----- rtl/cycloid_foot_trajectory.sv -----
// ----------------------------------------------------------------------------
// cycloid_foot_trajectory
// Foot position from gait tick: cycloid swing, linear stance return.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock, results in order. DW = max(log2(PHASE_TABLE_SIZE)
// + 8, 18) is the number of restoring divide stages shared by the swing phase and stance
// interpolation divisions. A stalled output freezes the whole pipe. Registers are written
// over APB at byte address 4 * index; a zero tick count acts as one.
// PHASE_TABLE_SIZE must be a power of two.
module cycloid_foot_trajectory #(
	parameter int PHASE_TABLE_SIZE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	cft_in_if.sink      in_ch,
	cft_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cft_pkg::*;

	localparam int LG  = $clog2(PHASE_TABLE_SIZE);
	localparam int QTR = PHASE_TABLE_SIZE / 4;
	localparam int PW  = LG + 1;
	localparam int IW  = $clog2(QTR + 1);
	localparam int DW  = (LG + 8 > 18) ? LG + 8 : 18;
	localparam int FW  = 33;

	typedef logic [15:0] qtab_t [0:QTR];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int k = 0; k <= QTR; k++) begin
			t[k] = quarter_sine(k, LG);
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// full-wave sine from the quarter table
	function automatic logic signed [16:0] phase_sine(input logic [LG-1:0] p);
		logic [LG:0] idx;
		logic        neg;
		logic [15:0] v;
		neg = 1'b0;
		if (p <= LG'(QTR)) begin
			idx = {1'b0, p};
		end else if (p <= LG'(2 * QTR)) begin
			idx = (LG+1)'(2 * QTR) - {1'b0, p};
		end else if (p <= LG'(3 * QTR)) begin
			idx = {1'b0, p} - (LG+1)'(2 * QTR);
			neg = 1'b1;
		end else begin
			idx = (LG+1)'(PHASE_TABLE_SIZE) - {1'b0, p};
			neg = 1'b1;
		end
		v = QTAB[idx[IW-1:0]];
		return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

	// ---------------- configuration registers ----------------
	logic [7:0]        swing_q, stance_q;
	logic signed [7:0] start_q, end_q;
	logic [6:0]        lh_q;
	logic signed [6:0] lo_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swing_q  <= RST_SWING_TICKS;
			stance_q <= RST_STANCE_TICKS;
			start_q  <= RST_START_POSITION;
			end_q    <= RST_END_POSITION;
			lh_q     <= RST_LIFT_HEIGHT;
			lo_q     <= RST_LIFT_OFFSET;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SWING_TICKS:    swing_q  <= pwdata[7:0];
				REG_STANCE_TICKS:   stance_q <= pwdata[7:0];
				REG_START_POSITION: start_q  <= pwdata[7:0];
				REG_END_POSITION:   end_q    <= pwdata[7:0];
				REG_LIFT_HEIGHT:    lh_q     <= pwdata[6:0];
				REG_LIFT_OFFSET:    lo_q     <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[4:2])
			REG_SWING_TICKS:    prdata = {24'd0, swing_q};
			REG_STANCE_TICKS:   prdata = {24'd0, stance_q};
			REG_START_POSITION: prdata = {{24{start_q[7]}}, start_q};
			REG_END_POSITION:   prdata = {{24{end_q[7]}}, end_q};
			REG_LIFT_HEIGHT:    prdata = {25'd0, lh_q};
			REG_LIFT_OFFSET:    prdata = {{25{lo_q[6]}}, lo_q};
			default:            prdata = 32'd0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic adv;
	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_sd [0:DW];

	assign adv         = !vld_s7 || out_ch.ready;
	assign in_ch.ready = adv;

	// ---------------- stage 1: phase / stance numerator ----------------
	logic [7:0]         sw_eff, st_eff;
	logic               swing_in;
	logic signed [8:0]  diff_in, tt_in;
	logic signed [18:0] num_in, mag_in;

	always_comb begin
		sw_eff   = (swing_q == 8'd0) ? 8'd1 : swing_q;
		st_eff   = (stance_q == 8'd0) ? 8'd1 : stance_q;
		swing_in = in_ch.tick <= sw_eff;
		diff_in  = {start_q[7], start_q} - {end_q[7], end_q};
		tt_in    = $signed({1'b0, in_ch.tick}) - $signed({1'b0, sw_eff});
		num_in   = 19'(diff_in * tt_in) + 19'(end_q * $signed({1'b0, st_eff}));
		mag_in   = (num_in < 0) ? -num_in : num_in;
	end

	// divider stage arrays, index 0 is stage 1
	logic [DW-1:0] dq_sd    [0:DW];
	logic [7:0]    rem_sd   [0:DW];
	logic [7:0]    dvs_sd   [0:DW];
	logic          swing_sd [0:DW];
	logic          neg_sd   [0:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			swing_sd[0] <= swing_in;
			neg_sd[0]   <= !swing_in && (num_in < 0);
			rem_sd[0]   <= 8'd0;
			dvs_sd[0]   <= swing_in ? sw_eff : st_eff;
			dq_sd[0]    <= swing_in ? DW'({in_ch.tick, LG'(0)}) : DW'(mag_in[16:0]);
		end
	end

	// ---------------- restoring divide, one quotient bit per stage ----------------
	for (genvar j = 0; j < DW; j++) begin : g_div
		logic [8:0] trial;
		logic       ge;

		assign trial = {rem_sd[j], dq_sd[j][DW-1]};
		assign ge    = trial >= {1'b0, dvs_sd[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j+1] <= 1'b0;
			end else if (adv) begin
				vld_sd[j+1] <= vld_sd[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sd[j+1]   <= ge ? 8'(trial - {1'b0, dvs_sd[j]}) : trial[7:0];
				dq_sd[j+1]    <= {dq_sd[j][DW-2:0], ge};
				dvs_sd[j+1]   <= dvs_sd[j];
				swing_sd[j+1] <= swing_sd[j];
				neg_sd[j+1]   <= neg_sd[j];
			end
		end
	end

	// ---------------- stage 3: sine, cosine, stance result ----------------
	logic [PW-1:0]      p_s3, p_s4;
	logic signed [16:0] sin_s3, cos_s3;
	logic               swing_s3, swing_s4, swing_s5, swing_s6, swing_s7;
	logic signed [8:0]  hst_s3, hst_s4, hst_s5, hst_s6;
	logic [LG-1:0]      pm_d, pc_d;
	logic signed [DW:0] qs_d;

	always_comb begin
		pm_d = dq_sd[DW][LG-1:0];
		pc_d = pm_d + LG'(QTR);
		qs_d = neg_sd[DW] ? -$signed({1'b0, dq_sd[DW]}) : $signed({1'b0, dq_sd[DW]});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3     <= dq_sd[DW][PW-1:0];
			sin_s3   <= phase_sine(pm_d);
			cos_s3   <= phase_sine(pc_d);
			swing_s3 <= swing_sd[DW];
			hst_s3   <= sat9(48'(qs_d));
		end
	end

	// ---------------- stage 4: sine correction product, lift numerator ----------------
	logic signed [39:0] sprod_s4;
	logic signed [27:0] lnum_s4;
	logic signed [18:0] one_minus_c;

	assign one_minus_c = 19'sd32768 - 19'(cos_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			sprod_s4 <= 40'(sin_s3 * $signed({1'b0, INV_TWO_PI_Q24}));
			lnum_s4  <= 28'(one_minus_c * $signed({1'b0, lh_q})) + (28'(lo_q) <<< 16);
			p_s4     <= p_s3;
			swing_s4 <= swing_s3;
			hst_s4   <= hst_s3;
		end
	end

	// ---------------- stage 5: cycloid fraction, vertical result ----------------
	logic signed [FW-1:0] f_s5;
	logic signed [8:0]    vy_s5, vy_s6, vy_s7;
	logic [39:0]          smag;
	logic signed [31:0]   scorr;
	logic [27:0]          lmag;
	logic signed [12:0]   lift;

	always_comb begin
		smag  = (sprod_s4 < 0) ? 40'(-sprod_s4) : 40'(sprod_s4);
		scorr = (sprod_s4 < 0) ? -$signed(32'(smag >> 9)) : $signed(32'(smag >> 9));
		lmag  = (lnum_s4 < 0) ? 28'(-lnum_s4) : 28'(lnum_s4);
		lift  = (lnum_s4 < 0) ? -$signed(13'(lmag >> 16)) : $signed(13'(lmag >> 16));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5     <= $signed(FW'({p_s4, (FRAC_BITS-LG)'(0)})) - FW'(scorr);
			vy_s5    <= sat9(-48'(lift));
			swing_s5 <= swing_s4;
			hst_s5   <= hst_s4;
		end
	end

	// ---------------- stage 6: horizontal span product ----------------
	logic signed [41:0] hprod_s6;
	logic signed [8:0]  span;

	assign span = {end_q[7], end_q} - {start_q[7], start_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			hprod_s6 <= 42'(span * f_s5);
			vy_s6    <= vy_s5;
			swing_s6 <= swing_s5;
			hst_s6   <= hst_s5;
		end
	end

	// ---------------- stage 7: output register ----------------
	logic signed [42:0] tot;
	logic [42:0]        tmag;
	logic signed [13:0] tq;
	logic signed [8:0]  hx_s7;

	always_comb begin
		tot  = (43'(start_q) <<< FRAC_BITS) + 43'(hprod_s6);
		tmag = (tot < 0) ? 43'(-tot) : 43'(tot);
		tq   = (tot < 0) ? -$signed(14'(tmag >> FRAC_BITS)) : $signed(14'(tmag >> FRAC_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_sd[DW];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s7    <= swing_s6 ? sat9(48'(tq)) : hst_s6;
			vy_s7    <= swing_s6 ? vy_s6 : 9'sd0;
			swing_s7 <= swing_s6;
		end
	end

	assign out_ch.valid               = vld_s7;
	assign out_ch.horizontal_position = hx_s7;
	assign out_ch.vertical_position   = swing_s7 ? vy_s7 : 9'sd0;

endmodule

// ----- tb/tb_cycloid_foot_trajectory.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycloid_foot_trajectory
// Checks foot coordinates against an in-bench fixed-point trajectory model.
// Ticks are streamed through the pipe under random gaps and output stalls,
// across several register settings written over APB while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_cycloid_foot_trajectory;
	import cft_pkg::*;

	localparam int N_PHASE   = 1024;
	localparam int LAT       = 24;
	localparam int MAX_CYC   = 400000;

	typedef struct packed {
		logic signed [8:0] hx;
		logic signed [8:0] vy;
	} foot_pos_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cft_in_if  in_ch ();
	cft_out_if out_ch ();

	cycloid_foot_trajectory i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// model copy of the registers
	logic [7:0]        m_swing, m_stance;
	logic signed [7:0] m_start, m_end;
	logic [6:0]        m_height;
	logic signed [6:0] m_offset;

	logic [7:0]  tick_queue [$];
	foot_pos_t   pos_queue [$];
	int          sine_tab [0:N_PHASE/4];
	int          errors, mismatches, n_sent, n_got, cycles;
	int          in_gap, out_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// quarter-wave table built the same way as the fixed-point definition
	function automatic int build_sine(int unsigned k);
		longint unsigned x, acc, term, r;
		x = (longint'(k) * 64'd1686629713) / N_PHASE;
		acc = x;
		term = x;
		for (int i = 1; i <= 8; i++) begin
			term = (term * x) >> 28;
			term = (term * x) >> 28;
			term = term / longint'((2 * i) * (2 * i + 1));
			if (i % 2 == 1) begin
				acc = (term <= acc) ? acc - term : 64'd0;
			end else begin
				acc = acc + term;
			end
		end
		r = (acc + 64'd4096) >> 13;
		if (r > 64'd32767) r = 64'd32767;
		return int'(r);
	endfunction

	function automatic longint phase_sin(int unsigned p);
		int unsigned q;
		q = N_PHASE / 4;
		p = p % N_PHASE;
		if (p <= q) return sine_tab[p];
		if (p <= 2 * q) return sine_tab[2 * q - p];
		if (p <= 3 * q) return -sine_tab[p - 2 * q];
		return -sine_tab[N_PHASE - p];
	endfunction

	function automatic logic signed [8:0] clamp9(longint v);
		if (v < -256) return -9'sd256;
		if (v > 255) return 9'sd255;
		return v[8:0];
	endfunction

	function automatic foot_pos_t foot_at_tick(logic [7:0] t);
		foot_pos_t r;
		longint sw, st, p, pm, s, c, f, tot, lift, num;
		sw = (m_swing == 0) ? 1 : m_swing;
		st = (m_stance == 0) ? 1 : m_stance;
		if (t <= sw) begin
			p = (longint'(t) * N_PHASE) / sw;
			pm = p % N_PHASE;
			s = phase_sin(pm);
			c = phase_sin((pm + N_PHASE / 4) % N_PHASE);
			f = ((p <<< 30) / N_PHASE) - (s * 64'sd2670177) / 512;
			tot = longint'(m_start) * 64'sd1073741824 + longint'(m_end - m_start) * f;
			lift = (longint'(m_height) * (32768 - c) + longint'(m_offset) * 65536) / 65536;
			r.hx = clamp9(tot / 64'sd1073741824);
			r.vy = clamp9(-lift);
		end else begin
			num = longint'(m_start - m_end) * (longint'(t) - sw) + longint'(m_end) * st;
			r.hx = clamp9(num / st);
			r.vy = 9'sd0;
		end
		return r;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.tick <= 8'd0;
			in_gap <= 0;
		end else begin
			if (!in_ch.valid || in_ch.ready) begin
				if (in_ch.valid) n_sent <= n_sent + 1;
				if (in_gap > 0) begin
					in_ch.valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (tick_queue.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.tick <= tick_queue.pop_front();
					in_gap <= rand_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// output stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_gap <= 0;
		end else if (out_gap > 0) begin
			out_ch.ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			out_ch.ready <= 1'b1;
			out_gap <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
		end
	end

	// prediction on input accept
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) pos_queue.push_back(foot_at_tick(in_ch.tick));
	end

	// result monitor
	always @(posedge clk) begin
		foot_pos_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_got <= n_got + 1;
			if (pos_queue.size() == 0) begin
				errors <= errors + 1;
				$display("unexpected item: hx=%0d vy=%0d", out_ch.horizontal_position,
					out_ch.vertical_position);
			end else begin
				want = pos_queue.pop_front();
				if (want.hx !== out_ch.horizontal_position
						|| want.vy !== out_ch.vertical_position) begin
					errors <= errors + 1;
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: hx exp %0d got %0d, vy exp %0d got %0d",
							want.hx, out_ch.horizontal_position, want.vy,
							out_ch.vertical_position);
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycles > MAX_CYC) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic apb_write(cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_SWING_TICKS:    m_swing = val[7:0];
			REG_STANCE_TICKS:   m_stance = val[7:0];
			REG_START_POSITION: m_start = val[7:0];
			REG_END_POSITION:   m_end = val[7:0];
			REG_LIFT_HEIGHT:    m_height = val[6:0];
			REG_LIFT_OFFSET:    m_offset = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [7:0] sw, logic [7:0] st, logic [7:0] sp, logic [7:0] ep,
			logic [6:0] lh, logic [6:0] lo);
		apb_write(REG_SWING_TICKS, {24'd0, sw});
		apb_write(REG_STANCE_TICKS, {24'd0, st});
		apb_write(REG_START_POSITION, {{24{sp[7]}}, sp});
		apb_write(REG_END_POSITION, {{24{ep[7]}}, ep});
		apb_write(REG_LIFT_HEIGHT, {25'd0, lh});
		apb_write(REG_LIFT_OFFSET, {{25{lo[6]}}, lo});
	endtask

	// wait until the pipe has drained
	task automatic drain();
		while (tick_queue.size() > 0 || in_ch.valid || pos_queue.size() > 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	// mostly ticks within one gait cycle, some beyond it
	task automatic random_ticks(int n);
		int cyc;
		cyc = ((m_swing == 0) ? 1 : m_swing) + ((m_stance == 0) ? 1 : m_stance);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8 && cyc <= 255) tick_queue.push_back($urandom_range(0, cyc));
			else tick_queue.push_back($urandom_range(0, 255));
		end
	endtask

	initial begin
		int phase;
		errors = 0; mismatches = 0; n_sent = 0; n_got = 0; cycles = 0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.tick = '0; out_ch.ready = 1'b0;
		m_swing = RST_SWING_TICKS; m_stance = RST_STANCE_TICKS;
		m_start = RST_START_POSITION; m_end = RST_END_POSITION;
		m_height = RST_LIFT_HEIGHT; m_offset = RST_LIFT_OFFSET;
		for (int k = 0; k <= N_PHASE / 4; k++) sine_tab[k] = build_sine(k);
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: swing ends, stance, past cycle
		tick_queue.push_back(8'd0);   tick_queue.push_back(8'd1);
		tick_queue.push_back(8'd5);   tick_queue.push_back(8'd10);
		tick_queue.push_back(8'd11);  tick_queue.push_back(8'd25);
		tick_queue.push_back(8'd26);  tick_queue.push_back(8'd255);
		drain();
		// zero tick counts act as one, extreme positions and lift
		set_all(8'd0, 8'd0, 8'h80, 8'h7f, 7'h7f, 7'h40);
		tick_queue.push_back(8'd0); tick_queue.push_back(8'd1);
		tick_queue.push_back(8'd2); tick_queue.push_back(8'd255);
		drain();
		set_all(8'd255, 8'd255, 8'h7f, 8'h80, 7'h7f, 7'h3f);
		tick_queue.push_back(8'd0);   tick_queue.push_back(8'd64);
		tick_queue.push_back(8'd127); tick_queue.push_back(8'd128);
		tick_queue.push_back(8'd191); tick_queue.push_back(8'd254);
		tick_queue.push_back(8'd255);
		drain();

		// random settings, a few at the extremes
		for (phase = 0; phase < 18; phase++) begin
			if (phase % 6 == 5)
				set_all(8'd1, 8'd1, 8'h80, 8'h7f, 7'd0, 7'h40);
			else
				set_all($urandom_range(0, 40), $urandom_range(0, 60), $urandom, $urandom,
					$urandom, $urandom);
			random_ticks(100);
			drain();
		end
		$display("covered %0d ticks over 21 register settings, %0d results checked",
			n_sent, n_got);
		if (errors == 0 && pos_queue.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
